// ----- src/d2n_pkg.sv -----
// shared constants and types of the depth to normal map block
`timescale 1ns / 1ps
package d2n_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_DEPTH_BITS = 16;

  localparam int DEPTH_W    = 16;
  localparam int POS_W      = 13;
  localparam int OUT_POS_W  = 11;
  localparam int NORM_W     = 16;
  localparam int DIM_W      = 12;
  localparam int FOCAL_W    = 20;
  localparam int CENTER_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int JOBQ_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd5;

  // one interior pixel waiting for the normal datapath
  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [DEPTH_W-1:0] dl;
    logic [DEPTH_W-1:0] dc;
    logic [DEPTH_W-1:0] dr;
    logic [DEPTH_W-1:0] du;
    logic [DEPTH_W-1:0] dd;
    logic               have_depth;
  } d2n_job_t;

  typedef struct packed {
    logic [FOCAL_W-1:0]  focal_x;
    logic [FOCAL_W-1:0]  focal_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } d2n_cam_t;

endpackage

// ----- src/d2n_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module d2n_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- src/d2n_fifo.sv -----
// short job queue between the window front end and the normal datapath
`timescale 1ns / 1ps
module d2n_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  d2n_pkg::d2n_job_t din,
  output logic              full,
  input  logic              pop,
  output d2n_pkg::d2n_job_t dout,
  output logic              empty
);
  import d2n_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  d2n_job_t          slot_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/d2n_front.sv -----
// raster counters, line buffers and 3x3 window, emits one job per interior pixel
`timescale 1ns / 1ps
module d2n_front #(
  parameter int MAX_WIDTH  = d2n_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = d2n_pkg::DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS = d2n_pkg::DEF_DEPTH_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic [d2n_pkg::DEPTH_W-1:0] in_depth_sample,
  output logic                        in_full,
  input  logic [d2n_pkg::DIM_W-1:0]   image_width,
  input  logic [d2n_pkg::DIM_W-1:0]   image_height,
  input  logic                        q_full,
  output logic                        q_push,
  output d2n_pkg::d2n_job_t           q_job
);
  import d2n_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WC_W    = $clog2(MAX_WIDTH + 1);
  localparam int HC_W    = $clog2(MAX_HEIGHT + 1);
  localparam int STORE_W = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;

  logic [COL_W-1:0]   col_r, col_nxt, col_e, cur_col_r;
  logic [ROW_W-1:0]   row_r, row_nxt, row_e, cur_row_r;
  logic [WC_W-1:0]    w_lim, col_inc;
  logic [HC_W-1:0]    h_lim, row_tmp, row_inc;
  logic               busy_r, accept, emit;
  logic [STORE_W-1:0] d_r, t2_r, m4_r, m5_r, b8_r, rd_above, rd_two;

  assign in_full = busy_r | q_full;
  assign accept  = in_push & ~in_full;

  // frame size limits
  always_comb begin
    if (image_width < DIM_W'(3)) begin
      w_lim = WC_W'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_lim = WC_W'(MAX_WIDTH);
    end else begin
      w_lim = WC_W'(image_width);
    end
    if (image_height < DIM_W'(3)) begin
      h_lim = HC_W'(3);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_lim = HC_W'(MAX_HEIGHT);
    end else begin
      h_lim = HC_W'(image_height);
    end
  end

  // position of the accepted sample and the position after it
  always_comb begin
    if (WC_W'(col_r) >= w_lim) begin
      col_e   = '0;
      row_tmp = HC_W'(row_r) + HC_W'(1);
    end else begin
      col_e   = col_r;
      row_tmp = HC_W'(row_r);
    end
    row_e   = (row_tmp >= h_lim) ? '0 : row_tmp[ROW_W-1:0];
    col_inc = WC_W'(col_e) + WC_W'(1);
    if (col_inc >= w_lim) begin
      col_nxt = '0;
      row_inc = HC_W'(row_e) + HC_W'(1);
      row_nxt = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_inc = HC_W'(row_e);
      row_nxt = row_e;
    end
  end

  d2n_ram #(.WIDTH(STORE_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (busy_r),
    .waddr (cur_col_r),
    .wdata (d_r),
    .re    (accept),
    .raddr (col_e),
    .rdata (rd_above)
  );

  d2n_ram #(.WIDTH(STORE_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (busy_r),
    .waddr (cur_col_r),
    .wdata (rd_above),
    .re    (accept),
    .raddr (col_e),
    .rdata (rd_two)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
      t2_r   <= '0;
      m4_r   <= '0;
      m5_r   <= '0;
      b8_r   <= '0;
    end else begin
      busy_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (busy_r) begin
        t2_r <= rd_two;
        m4_r <= m5_r;
        m5_r <= rd_above;
        b8_r <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_r       <= in_depth_sample[STORE_W-1:0];
      cur_col_r <= col_e;
      cur_row_r <= row_e;
    end
  end

  assign emit   = (cur_row_r >= ROW_W'(2)) && (cur_col_r >= COL_W'(2));
  assign q_push = busy_r & emit;

  always_comb begin
    q_job.row        = POS_W'(cur_row_r - ROW_W'(1));
    q_job.col        = POS_W'(cur_col_r - COL_W'(1));
    q_job.du         = DEPTH_W'(t2_r);
    q_job.dl         = DEPTH_W'(m4_r);
    q_job.dc         = DEPTH_W'(m5_r);
    q_job.dr         = DEPTH_W'(rd_above);
    q_job.dd         = DEPTH_W'(b8_r);
    q_job.have_depth = (t2_r != '0) && (m4_r != '0) && (m5_r != '0) &&
                       (rd_above != '0) && (b8_r != '0);
  end

endmodule

// ----- src/d2n_back.sv -----
// sequential normal datapath: cross product, scaling, root, divide, output register
`timescale 1ns / 1ps
module d2n_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  d2n_pkg::d2n_cam_t                   cam,
  input  logic                                q_empty,
  input  d2n_pkg::d2n_job_t                   q_job,
  output logic                                q_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [d2n_pkg::OUT_POS_W-1:0]       out_pixel_row,
  output logic [d2n_pkg::OUT_POS_W-1:0]       out_pixel_col,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_z,
  output logic                                out_normal_valid
);
  import d2n_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HT    = 4'd1;
  localparam logic [3:0] S_SV    = 4'd2;
  localparam logic [3:0] S_ST    = 4'd3;
  localparam logic [3:0] S_F0    = 4'd4;
  localparam logic [3:0] S_F1    = 4'd5;
  localparam logic [3:0] S_PA    = 4'd6;
  localparam logic [3:0] S_QB    = 4'd7;
  localparam logic [3:0] S_F2    = 4'd8;
  localparam logic [3:0] S_MAG   = 4'd9;
  localparam logic [3:0] S_SCALE = 4'd10;
  localparam logic [3:0] S_SQ    = 4'd11;
  localparam logic [3:0] S_SQRT  = 4'd12;
  localparam logic [3:0] S_DLOAD = 4'd13;
  localparam logic [3:0] S_DIV   = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]               state_r;
  d2n_job_t                 job_r;
  logic signed [35:0]       ht_r, sv_r;
  logic [35:0]              st_r;
  logic signed [63:0]       f0_r, f1_r, pa_r, qb_r, f2_r;
  logic [63:0]              mag_r [3];
  logic [2:0]               neg_r;
  logic [1:0]               idx_r;
  logic [63:0]              sum_r, sum_nxt, x_r, trial;
  logic [63:0]              r_r;
  logic [62:0]              bit_r;
  logic [48:0]              rem_r, dsh_r;
  logic [15:0]              q_r, q_nxt;
  logic [3:0]               cnt_r;
  logic [NORM_W-1:0]        nres_r [3];
  logic                     res_valid_r, ovalid_r;

  logic signed [16:0]       hd, vd;
  logic [16:0]              s, t;
  logic signed [18:0]       p, q;
  logic [FOCAL_W-1:0]       fx, fy;
  logic signed [20:0]       mul_a;
  logic signed [35:0]       mul_b;
  logic signed [56:0]       prod;
  logic [63:0]              m01, mx;
  logic [30:0]              sq_in;
  logic                     load_out;

  assign hd = $signed({1'b0, job_r.dr}) - $signed({1'b0, job_r.dl});
  assign vd = $signed({1'b0, job_r.dd}) - $signed({1'b0, job_r.du});
  assign s  = {1'b0, job_r.dr} + {1'b0, job_r.dl};
  assign t  = {1'b0, job_r.dd} + {1'b0, job_r.du};
  assign p  = $signed({2'b0, job_r.col, 4'b0}) - $signed({3'b0, cam.center_x});
  assign q  = $signed({2'b0, job_r.row, 4'b0}) - $signed({3'b0, cam.center_y});
  assign fx = (cam.focal_x == '0) ? FOCAL_W'(1) : cam.focal_x;
  assign fy = (cam.focal_y == '0) ? FOCAL_W'(1) : cam.focal_y;

  // shared multiplier for the cross product terms
  always_comb begin
    mul_a = 21'(hd);
    mul_b = $signed({19'b0, t});
    unique case (state_r)
      S_SV: begin
        mul_a = 21'(vd);
        mul_b = $signed({19'b0, s});
      end
      S_ST: begin
        mul_a = $signed({4'b0, s});
        mul_b = $signed({19'b0, t});
      end
      S_F0: begin
        mul_a = $signed({1'b0, fx});
        mul_b = ht_r;
      end
      S_F1: begin
        mul_a = $signed({1'b0, fy});
        mul_b = sv_r;
      end
      S_PA: begin
        mul_a = 21'(p);
        mul_b = ht_r;
      end
      S_QB: begin
        mul_a = 21'(q);
        mul_b = sv_r;
      end
      default: begin
        mul_a = 21'(hd);
        mul_b = $signed({19'b0, t});
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign m01     = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign mx      = (m01 > mag_r[2]) ? m01 : mag_r[2];
  assign sq_in   = mag_r[idx_r][30:0];
  assign sum_nxt = sum_r + 64'(sq_in * sq_in);
  assign trial   = r_r + 64'(bit_r);
  assign q_nxt   = {q_r[14:0], (rem_r >= dsh_r)};

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign load_out  = (state_r == S_DONE) && (!ovalid_r || out_pop);
  assign out_empty = ~ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            state_r <= q_job.have_depth ? S_HT : S_DONE;
          end
        end
        S_HT:    state_r <= S_SV;
        S_SV:    state_r <= S_ST;
        S_ST:    state_r <= S_F0;
        S_F0:    state_r <= S_F1;
        S_F1:    state_r <= S_PA;
        S_PA:    state_r <= S_QB;
        S_QB:    state_r <= S_F2;
        S_F2:    state_r <= S_MAG;
        S_MAG:   state_r <= S_SCALE;
        S_SCALE: begin
          if (mx == '0) begin
            state_r <= S_DONE;
          end else if (mx[63:31] == '0 && mx[30]) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (idx_r == 2'd2) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_r[0]) begin
            state_r <= S_DLOAD;
          end
        end
        S_DLOAD: state_r <= S_DIV;
        S_DIV: begin
          if (cnt_r == 4'd15) begin
            state_r <= (idx_r == 2'd2) ? S_DONE : S_DLOAD;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        job_r       <= q_job;
        res_valid_r <= 1'b0;
        nres_r[0]   <= '0;
        nres_r[1]   <= '0;
        nres_r[2]   <= '0;
      end
      S_HT: ht_r <= prod[35:0];
      S_SV: sv_r <= prod[35:0];
      S_ST: st_r <= prod[35:0];
      S_F0: f0_r <= 64'(prod);
      S_F1: f1_r <= 64'(prod);
      S_PA: pa_r <= 64'(prod);
      S_QB: qb_r <= 64'(prod);
      S_F2: f2_r <= -(pa_r + qb_r + $signed({24'b0, st_r, 4'b0}));
      S_MAG: begin
        neg_r    <= {f2_r[63], f1_r[63], f0_r[63]};
        mag_r[0] <= f0_r[63] ? 64'(-f0_r) : 64'(f0_r);
        mag_r[1] <= f1_r[63] ? 64'(-f1_r) : 64'(f1_r);
        mag_r[2] <= f2_r[63] ? 64'(-f2_r) : 64'(f2_r);
      end
      S_SCALE: begin
        idx_r <= 2'd0;
        sum_r <= '0;
        if (mx[63:31] != '0) begin
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else if (mx != '0 && !mx[30]) begin
          mag_r[0] <= mag_r[0] << 1;
          mag_r[1] <= mag_r[1] << 1;
          mag_r[2] <= mag_r[2] << 1;
        end
      end
      S_SQ: begin
        sum_r <= sum_nxt;
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        x_r   <= sum_nxt;
        r_r   <= '0;
        bit_r <= {1'b1, 62'b0};
      end
      S_SQRT: begin
        // one root bit per cycle
        if (x_r >= trial) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + 64'(bit_r);
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DLOAD: begin
        rem_r <= 49'({sq_in, 15'b0}) + 49'(r_r);
        dsh_r <= {r_r[32:0], 16'b0};
        q_r   <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
        end
        dsh_r <= dsh_r >> 1;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          nres_r[idx_r] <= neg_r[idx_r] ? (~q_nxt + 16'd1) : q_nxt;
          idx_r         <= idx_r + 2'd1;
          res_valid_r   <= 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel_row    <= job_r.row[OUT_POS_W-1:0];
      out_pixel_col    <= job_r.col[OUT_POS_W-1:0];
      out_normal_x     <= nres_r[0];
      out_normal_y     <= nres_r[1];
      out_normal_z     <= nres_r[2];
      out_normal_valid <= res_valid_r;
    end
  end

endmodule

// ----- src/depth_to_normal_map.sv -----
// top level of the depth to normal map block
`timescale 1ns / 1ps
// usage
//   input: depth samples of a frame in raster order, one transaction per pixel
//   (in_push / in_full). the cycle that accepts a sample reads the two line
//   buffer rams at the current column, the next one writes them back and shifts
//   the 3x3 window, and in_full holds off the next sample during the write back
//   output: one transaction per interior pixel (out_empty / out_pop) with row,
//   column, a q1.14 unit normal and a valid flag; border pixels give nothing
//   each valid normal passes through the back end's one-bit-per-cycle scaling
//   shifter, the 32 step square root and three 16 step divides; a pixel with
//   missing depth skips them and goes straight to the output register
//   a 4 entry job queue lets the window run ahead of the datapath, so input is
//   stalled only while a sample is written back or that queue is full
//   a stalled receiver holds the result in the output register; the datapath
//   then finishes its next normal and waits, and the queue fills behind it
//   reset (synchronous, rst_n low) restarts the frame at row 0, column 0,
//   clears the window and loads the default intrinsics; no clearing pass
//   configuration (cfg_we, cfg_index, cfg_wdata) is to be written only while
//   idle; the user is bound to this, the block itself does not enforce it
module depth_to_normal_map #(
  parameter int MAX_WIDTH  = d2n_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = d2n_pkg::DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS = d2n_pkg::DEF_DEPTH_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [d2n_pkg::DEPTH_W-1:0]         in_depth_sample,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [d2n_pkg::OUT_POS_W-1:0]       out_pixel_row,
  output logic [d2n_pkg::OUT_POS_W-1:0]       out_pixel_col,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [d2n_pkg::NORM_W-1:0]   out_normal_z,
  output logic                                out_normal_valid,
  input  logic                                cfg_we,
  input  logic [d2n_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [d2n_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import d2n_pkg::*;

  logic [DIM_W-1:0] image_width_r, image_height_r;
  d2n_cam_t         cam_r;
  logic             q_push, q_full, q_pop, q_empty;
  d2n_job_t         q_din, q_dout;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_W'(640);
      image_height_r <= DIM_W'(480);
      cam_r.focal_x  <= FOCAL_W'(8192);
      cam_r.focal_y  <= FOCAL_W'(8192);
      cam_r.center_x <= CENTER_W'(5120);
      cam_r.center_y <= CENTER_W'(3840);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_FOCAL_X:      cam_r.focal_x  <= cfg_wdata[FOCAL_W-1:0];
        CFG_FOCAL_Y:      cam_r.focal_y  <= cfg_wdata[FOCAL_W-1:0];
        CFG_CENTER_X:     cam_r.center_x <= cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y:     cam_r.center_y <= cfg_wdata[CENTER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // window front end
  d2n_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_depth_sample (in_depth_sample),
    .in_full         (in_full),
    .image_width     (image_width_r),
    .image_height    (image_height_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_din)
  );

  // decoupling queue
  d2n_fifo #(.DEPTH(JOBQ_DEPTH)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // normal datapath with output register
  d2n_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cam              (cam_r),
    .q_empty          (q_empty),
    .q_job            (q_dout),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_col    (out_pixel_col),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_normal_valid (out_normal_valid)
  );

endmodule
